[sv/pims_pkg.sv]
// ----------------------------------------------------------------------------
// pims_pkg
// Shared types and constants for the pulse induction metal sensor.
// ----------------------------------------------------------------------------
package pims_pkg;

    localparam int CONV_BITS  = 10;
    localparam int CONV_W     = 10;
    localparam int SUM_W      = 18;
    localparam int CNT_W      = 8;
    localparam int TICK_W     = 16;
    localparam int HALF_W     = 9;
    localparam int AVG_W      = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CONV_W-1:0] CONV_MASK = (CONV_BITS >= CONV_W) ? {CONV_W{1'b1}} :
                                              CONV_W'((1 << CONV_BITS) - 1);
    localparam logic [AVG_W-1:0]  AVG_MAX   = {AVG_W{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DISCH,
        PH_HIGH,
        PH_LOW,
        PH_START,
        PH_WAIT
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DISCHARGE   = 3'd0,
        CFG_HALF_PERIOD = 3'd1,
        CFG_PULSES      = 3'd2,
        CFG_SAMPLES     = 3'd3,
        CFG_THRESHOLD   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[sv/pims_div.sv]
// ----------------------------------------------------------------------------
// pims_div
// Restoring divider, one quotient bit per clock, for the sample average.
// ----------------------------------------------------------------------------
module pims_div
    import pims_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [SUM_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;

    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;
    logic                 ge;
    logic [SUM_W-1:0]     quo_shift;
    logic                 last;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        diff      = ge ? (trial - {1'b0, dvs_reg}) : trial;
        quo_shift = {quo_reg[SUM_W-2:0], ge};
        last      = step_reg == DIV_CNT_W'(DIV_STEPS - 1);

        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = quo_shift;
            rem_next  = diff[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last;
    assign quotient  = quo_shift;

endmodule

[sv/pulse_induction_metal_sense.sv]
// ----------------------------------------------------------------------------
// pulse_induction_metal_sense
// Tick-driven pulse induction sensor sequencer with a serial average divider.
// ----------------------------------------------------------------------------
// Each input beat is one microsecond tick carrying the start request and the
// converter handshake; each accepted tick yields exactly one output beat with
// the capacitor, coil and convert pin levels plus busy, done, metal flag and
// the last average. Registers are written through cfg_we/cfg_addr/cfg_data;
// the user must write them only while the block is idle, which the block does
// not enforce itself; writes to unused indexes are dropped. An ordinary tick's
// output beat is registered, valid the cycle after the input beat is taken. The
// tick that takes the last conversion of a measurement starts the restoring
// divider, which works through the sample sum one bit at a time; its output
// beat is registered when the divide ends, and s_tready stays low while it is busy.
// The single output register lets a new tick be taken in the cycle its
// predecessor's beat is drained; while m_tready is low and a beat waits,
// s_tready is low and nothing is lost.
// Reset loads the default register values, returns the sequencer to idle,
// clears the stored average and metal flag and empties the output register.
// ----------------------------------------------------------------------------
module pulse_induction_metal_sense
    import pims_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // start_req, conv_done, conv_value[9:0], pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // cap_drive_low, coil_pulse, conv_start,
                                             // busy_res, done_res, metal_found, average[9:0]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TICK_W-1:0] disch_reg, disch_next;
    logic [TICK_W-1:0] half_per_reg, half_per_next;
    logic [CNT_W-1:0]  pulses_reg, pulses_next;
    logic [CNT_W-1:0]  samples_reg, samples_next;
    logic [AVG_W-1:0]  thr_reg, thr_next;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [HALF_W-1:0] half_reg, half_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic              metal_reg, metal_next;
    logic              m_valid_reg, m_valid_next;
    logic [15:0]       m_data_reg, m_data_next;

    logic              in_fire;
    logic              start_req;
    logic              conv_done;
    logic [CONV_W-1:0] conv_value;
    logic              cap, coil, cstart, busy;
    logic              load_out;
    logic              div_start;
    logic [TICK_W-1:0] tick_inc;
    div_stat_t         div_stat;
    logic [SUM_W-1:0]  quotient;
    logic [AVG_W-1:0]  avg_sat;
    logic              metal_new;

    pims_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign s_tready   = !div_stat.busy && (!m_valid_reg || m_tready);
    assign in_fire    = s_tvalid && s_tready;
    assign start_req  = s_tdata[0];
    assign conv_done  = s_tdata[1];
    assign conv_value = s_tdata[CONV_W+1:2] & CONV_MASK;
    assign tick_inc   = tick_reg + 1'b1;

    // saturate the quotient to the average range
    assign avg_sat   = (|quotient[SUM_W-1:AVG_W]) ? AVG_MAX : quotient[AVG_W-1:0];
    assign metal_new = avg_sat <= thr_reg;

    always_comb
    begin
        disch_next    = disch_reg;
        half_per_next = half_per_reg;
        pulses_next   = pulses_reg;
        samples_next  = samples_reg;
        thr_next      = thr_reg;

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DISCHARGE:   disch_next    = cfg_data[TICK_W-1:0];
                CFG_HALF_PERIOD: half_per_next = cfg_data[TICK_W-1:0];
                CFG_PULSES:      pulses_next   = cfg_data[CNT_W-1:0];
                CFG_SAMPLES:     samples_next  = cfg_data[CNT_W-1:0];
                CFG_THRESHOLD:   thr_next      = cfg_data[AVG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        half_next  = half_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        cap        = 1'b0;
        coil       = 1'b0;
        cstart     = 1'b0;
        busy       = 1'b1;
        load_out   = 1'b0;
        div_start  = 1'b0;

        if (in_fire)
        begin
            load_out = 1'b1;
            unique case (phase_reg)
                PH_DISCH:
                begin
                    cap       = 1'b1;
                    tick_next = tick_inc;
                    if (tick_inc >= disch_reg)
                    begin
                        tick_next  = '0;
                        half_next  = '0;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    coil      = 1'b1;
                    tick_next = tick_inc;
                    if (tick_inc >= half_per_reg)
                    begin
                        tick_next  = '0;
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= half_per_reg)
                    begin
                        tick_next  = '0;
                        half_next  = half_reg + 1'b1;
                        phase_next = ((half_reg + 1'b1) >= {1'b0, pulses_reg}) ?
                                     PH_START : PH_HIGH;
                    end
                end
                PH_START:
                begin
                    cstart     = 1'b1;
                    phase_next = PH_WAIT;
                end
                PH_WAIT:
                begin
                    if (conv_done)
                    begin
                        sum_next   = sum_reg + SUM_W'(conv_value);
                        count_next = count_reg + 1'b1;
                        tick_next  = '0;
                        if ((count_reg + 1'b1) >= samples_reg)
                        begin
                            // final sample: the beat goes out when the divide ends
                            div_start  = 1'b1;
                            load_out   = 1'b0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_DISCH;
                        end
                    end
                end
                PH_IDLE:
                begin
                    busy = 1'b0;
                    if (start_req)
                    begin
                        tick_next  = '0;
                        half_next  = '0;
                        count_next = '0;
                        sum_next   = '0;
                        phase_next = PH_DISCH;
                    end
                end
                default:
                begin
                    busy       = 1'b0;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        avg_next     = avg_reg;
        metal_next   = metal_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (div_stat.done)
        begin
            avg_next     = avg_sat;
            metal_next   = metal_new;
            m_valid_next = 1'b1;
            m_data_next  = {avg_sat, metal_new, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
        end
        else if (load_out)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {avg_reg, metal_reg, 1'b0, busy, cstart, coil, cap};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disch_reg    <= TICK_W'(500);
            half_per_reg <= TICK_W'(85);
            pulses_reg   <= CNT_W'(8);
            samples_reg  <= CNT_W'(40);
            thr_reg      <= AVG_W'(999);
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            half_reg     <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            avg_reg      <= '0;
            metal_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            disch_reg    <= disch_next;
            half_per_reg <= half_per_next;
            pulses_reg   <= pulses_next;
            samples_reg  <= samples_next;
            thr_reg      <= thr_next;
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            half_reg     <= half_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            avg_reg      <= avg_next;
            metal_reg    <= metal_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !s_tready)
        else $error("input taken while divider runs");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (count_reg != '0))
        else $error("divide with zero sample count");

    a_div_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> (m_valid_reg && m_data_reg[4] && m_data_reg[3]))
        else $error("divider result did not reach the output beat");

    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> $onehot0(m_data_reg[2:0]))
        else $error("more than one pin active in one tick");

    a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[4]) |-> m_data_reg[3])
        else $error("done beat without busy");

endmodule
